@@ src/q8_block_scaled_dot_accumulate_unit_assert.svh @@
// Assertion macros for the dot-accumulate top level
`ifndef Q8_BLOCK_SCALED_DOT_ACCUMULATE_UNIT_ASSERT_SVH
`define Q8_BLOCK_SCALED_DOT_ACCUMULATE_UNIT_ASSERT_SVH

// clocked property, masked while in reset
`define Q8BSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define Q8BSD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/q8bsd_pkg.sv @@
// Shared types, constants and fp32 helper functions for the dot-accumulate unit
`default_nettype none
package q8bsd_pkg;

  localparam int LANES_PER_WORD = 8;
  localparam int NUM_WORDS      = 4;
  localparam int LANE_SUM_W     = 19;
  localparam int DOT_W          = 21;
  localparam logic [31:0] QNAN  = 32'h7FC0_0000;
  localparam logic [31:0] PINF  = 32'h7F80_0000;

  // unpacked operand: value = mant * 2^xp unless a special class is set
  typedef struct packed {
    logic               sgn;
    logic               nan;
    logic               inf;
    logic               zero;
    logic [23:0]        mant;
    logic signed [11:0] xp;
  } fpu_t;

  function automatic fpu_t unpack_f32(input logic [31:0] b);
    fpu_t r;
    logic [7:0] e;
    e = b[30:23];
    r.sgn  = b[31];
    r.nan  = (e == 8'hFF) && (b[22:0] != 23'd0);
    r.inf  = (e == 8'hFF) && (b[22:0] == 23'd0);
    r.zero = (e == 8'h00) && (b[22:0] == 23'd0);
    r.mant = {(e != 8'h00), b[22:0]};
    r.xp   = $signed({4'b0, ((e == 8'h00) ? 8'd1 : e)}) - 12'sd150;
    return r;
  endfunction

  function automatic fpu_t unpack_f16(input logic [15:0] h);
    fpu_t r;
    logic [4:0] e;
    e = h[14:10];
    r.sgn  = h[15];
    r.nan  = (e == 5'h1F) && (h[9:0] != 10'd0);
    r.inf  = (e == 5'h1F) && (h[9:0] == 10'd0);
    r.zero = (e == 5'h00) && (h[9:0] == 10'd0);
    r.mant = {13'b0, (e != 5'h00), h[9:0]};
    r.xp   = $signed({7'b0, ((e == 5'h00) ? 5'd1 : e)}) - 12'sd25;
    return r;
  endfunction

  function automatic fpu_t unpack_int(input logic signed [DOT_W-1:0] d);
    fpu_t r;
    logic [DOT_W-1:0] mag;
    mag = d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
    r.sgn  = d[DOT_W-1];
    r.nan  = 1'b0;
    r.inf  = 1'b0;
    r.zero = (d == '0);
    r.mant = {{(24-DOT_W){1'b0}}, mag};
    r.xp   = 12'sd0;
    return r;
  endfunction

  // round m * 2^x (m non-zero) to fp32, nearest-even, subnormals kept
  function automatic logic [31:0] round_pack(input logic sgn, input logic [47:0] m,
                                             input logic signed [11:0] x);
    logic [5:0]         p;
    logic [47:0]        n;
    logic [47:0]        s;
    logic signed [12:0] be;
    logic signed [12:0] beff;
    logic signed [12:0] diff;
    logic [5:0]         sh;
    logic [12:0]        em1;
    logic [23:0]        mant;
    logic               lost;
    logic               rnd;
    logic [35:0]        t;
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) p = 6'(i);
    end
    n  = m << (6'd47 - p);
    be = {x[11], x} + $signed({7'b0, p}) + 13'sd127;
    if (be >= 13'sd1) begin
      beff = be;
      sh   = 6'd0;
    end else begin
      beff = 13'sd1;
      diff = 13'sd1 - be;
      sh   = (diff > 13'sd63) ? 6'd63 : diff[5:0];
    end
    lost = |(n & ((48'd1 << sh) - 48'd1));
    s    = n >> sh;
    mant = s[47:24];
    rnd  = s[23] & ((|s[22:0]) | lost | mant[0]);
    em1  = 13'(beff - 13'sd1);
    t    = {em1, 23'b0} + {12'b0, mant} + {35'b0, rnd};
    if (t[35:23] >= 13'd255) return {sgn, PINF[30:0]};
    return {sgn, t[30:0]};
  endfunction

endpackage
`default_nettype wire

@@ src/q8_block_scaled_dot_accumulate_unit.sv @@
// Q8 block-scaled dot product with fp32 row accumulation - top level
// Each input item is one 32-element sub-block of a matrix row: 32 int8 weights,
// 32 int8 activations, an fp16 weight scale and an fp32 activation scale, with
// in_tlast marking the final sub-block of a row. Four lanes of eight multipliers
// form the exact integer lane sums in the accept cycle while the two scales
// are multiplied; the lane sums are merged exactly, the scale is applied to
// the dot product and the result is added to the fp32 accumulator, both with
// IEEE round-to-nearest-even. An item passes the accept, merge, scale and add
// steps in turn; with the single fp32 accumulate, the next item waits for the
// add. On the last sub-block the row sum goes out on out_tdata (any NaN
// as 0x7FC00000) and the accumulator returns to +0. A waiting result does not
// block new items; only a further row end stalls in the add step until it is
// taken. Reset is synchronous, active low, and clears the accumulator to +0.
`default_nettype none
module q8_block_scaled_dot_accumulate_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // weights_0..3 [255:0], acts_0..3 [511:256], weight_scale [527:512],
  // act_scale [559:528]
  input  wire logic [559:0] in_tdata,
  input  wire logic         in_tlast,   // last_of_row
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata   // row_sum
);
  import q8bsd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MERGE = 4'b0010,
    ST_PROD  = 4'b0100,
    ST_ACC   = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      accept;
  logic                      acc_go;
  logic                      last_r;
  logic signed [LANE_SUM_W-1:0] psum [NUM_WORDS];
  logic signed [DOT_W-1:0]   dot_r;
  logic [31:0]               scale_r;
  logic [31:0]               prod_r;
  logic [31:0]               sum;
  logic                      out_tvalid_r;
  logic [31:0]               out_tdata_r;
  logic                      sum_nan;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  // a row end may not overwrite a result still waiting
  assign acc_go    = (state_r == ST_ACC) && !(last_r && out_tvalid_r && !out_tready);

  // lanes: one 64-bit weight word against its activation word each
  for (genvar g = 0; g < NUM_WORDS; g++) begin : g_lane
    q8bsd_lane u_lane (
      .clk    (clk),
      .load   (accept),
      .wts    (in_tdata[64*g +: 64]),
      .acts   (in_tdata[256 + 64*g +: 64]),
      .psum_r (psum[g])
    );
  end

  // wscale * ascale, taken straight from the ports at accept
  q8bsd_fmul u_scale_mul (
    .clk   (clk),
    .en    (accept),
    .op_a  (unpack_f16(in_tdata[527:512])),
    .op_b  (unpack_f32(in_tdata[559:528])),
    .res_r (scale_r)
  );

  // scale * dot; the integer is fed exactly, no separate conversion
  q8bsd_fmul u_dot_mul (
    .clk   (clk),
    .en    (state_r == ST_PROD),
    .op_a  (unpack_f32(scale_r)),
    .op_b  (unpack_int(dot_r)),
    .res_r (prod_r)
  );

  q8bsd_facc u_facc (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (acc_go),
    .clear  (last_r),
    .addend (prod_r),
    .sum    (sum)
  );

  assign sum_nan = (sum[30:23] == 8'hFF) && (sum[22:0] != 23'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_MERGE;
      ST_MERGE: state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_ACC;
      ST_ACC:   if (acc_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_go && last_r) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) last_r <= in_tlast;
    if (state_r == ST_MERGE) begin
      dot_r <= DOT_W'(psum[0]) + DOT_W'(psum[1]) + DOT_W'(psum[2]) + DOT_W'(psum[3]);
    end
    if (acc_go && last_r) out_tdata_r <= sum_nan ? QNAN : sum;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`include "q8_block_scaled_dot_accumulate_unit_assert.svh"

  `Q8BSD_CHECK_NEXT(a_accept_to_merge, accept, state_r == ST_MERGE, "accepted item did not move to merge")
  `Q8BSD_CHECK_NEXT(a_row_end_emits, acc_go && last_r, out_tvalid_r, "row end gave no result")
  `Q8BSD_ASSERT(a_result_from_acc, $rose(out_tvalid_r) |-> $past(state_r == ST_ACC), "result raised outside add step")
  `Q8BSD_CHECK_NEXT(a_no_overwrite, (state_r == ST_ACC) && last_r && out_tvalid_r && !out_tready, state_r == ST_ACC, "pending result overwritten")

endmodule
`default_nettype wire

@@ src/q8bsd_lane.sv @@
// One lane: signed int8 dot product of eight weight/activation pairs, registered
`default_nettype none
module q8bsd_lane (
  input  wire logic                                  clk,
  input  wire logic                                  load,
  input  wire logic [63:0]                           wts,
  input  wire logic [63:0]                           acts,
  output logic signed [q8bsd_pkg::LANE_SUM_W-1:0]    psum_r
);
  import q8bsd_pkg::*;

  logic signed [LANE_SUM_W-1:0] psum_nxt;

  always_comb begin
    psum_nxt = '0;
    for (int k = 0; k < LANES_PER_WORD; k++) begin
      psum_nxt = psum_nxt + LANE_SUM_W'($signed(wts[8*k +: 8]) * $signed(acts[8*k +: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (load) psum_r <= psum_nxt;
  end
endmodule
`default_nettype wire

@@ src/q8bsd_fmul.sv @@
// fp multiplier on unpacked operands, single rounding, registered result
`default_nettype none
module q8bsd_fmul (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire q8bsd_pkg::fpu_t  op_a,
  input  wire q8bsd_pkg::fpu_t  op_b,
  output logic [31:0]           res_r
);
  import q8bsd_pkg::*;

  logic        sgn;
  logic [47:0] prod;
  logic [31:0] res_nxt;

  assign sgn  = op_a.sgn ^ op_b.sgn;
  assign prod = op_a.mant * op_b.mant;

  always_comb begin
    if (op_a.nan || op_b.nan || (op_a.inf && op_b.zero) || (op_a.zero && op_b.inf)) begin
      res_nxt = QNAN;
    end else if (op_a.inf || op_b.inf) begin
      res_nxt = {sgn, PINF[30:0]};
    end else if (op_a.zero || op_b.zero) begin
      res_nxt = {sgn, 31'b0};
    end else begin
      res_nxt = round_pack(sgn, prod, op_a.xp + op_b.xp);
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end
endmodule
`default_nettype wire

@@ src/q8bsd_facc.sv @@
// fp32 row accumulator: acc + addend with nearest-even rounding, cleared at row end
`default_nettype none
module q8bsd_facc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        clear,
  input  wire logic [31:0] addend,
  output logic [31:0]      sum
);
  import q8bsd_pkg::*;

  logic [31:0]       acc_r;
  logic [31:0]       acc_nxt;
  fpu_t              ua, ub, big, sml;
  logic              swap;
  logic [11:0]       dexp;
  logic [4:0]        d;
  logic [26:0]       mb, ms, ms_al;
  logic [27:0]       s;

  always_comb begin
    ua    = unpack_f32(acc_r);
    ub    = unpack_f32(addend);
    swap  = addend[30:0] > acc_r[30:0];
    big   = swap ? ub : ua;
    sml   = swap ? ua : ub;
    dexp  = 12'(big.xp - sml.xp);
    d     = (dexp > 12'd31) ? 5'd31 : dexp[4:0];
    mb    = {big.mant, 3'b0};
    ms    = {sml.mant, 3'b0};
    // sticky folded into the lsb
    ms_al = (ms >> d) | {26'b0, |(ms & ((27'd1 << d) - 27'd1))};
    s     = (big.sgn != sml.sgn) ? ({1'b0, mb} - {1'b0, ms_al}) : ({1'b0, mb} + {1'b0, ms_al});
    if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sgn != ub.sgn))) begin
      sum = QNAN;
    end else if (ua.inf) begin
      sum = {ua.sgn, PINF[30:0]};
    end else if (ub.inf) begin
      sum = {ub.sgn, PINF[30:0]};
    end else if (s == 28'd0) begin
      sum = {ua.sgn & ub.sgn, 31'b0};
    end else begin
      sum = round_pack(big.sgn, {20'b0, s}, big.xp - 12'sd3);
    end
    acc_nxt = clear ? 32'd0 : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else if (en) begin
      acc_r <= acc_nxt;
    end
  end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the q8 block-scaled dot-accumulate unit
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import q8bsd_pkg::*;

  // Unpacked float operand: value = mant * 2^xp unless a special flag is set
  typedef struct {
    bit          sgn;
    bit          nan;
    bit          inf;
    bit          zero;
    logic [23:0] mant;
    int          xp;
    logic [31:0] raw;
  } fp_val_t;

  // Row-sum predictor plus a queue of sums still owed by the unit
  class row_sum_board;
    logic [31:0] acc;
    logic [31:0] row_sums_q[$];
    int          errors;

    function new();
      acc    = 32'h0000_0000;
      errors = 0;
    endfunction

    function fp_val_t from_f32(logic [31:0] b);
      fp_val_t v;
      logic [7:0] e;
      e      = b[30:23];
      v.sgn  = b[31];
      v.nan  = (e == 8'hFF) && (b[22:0] != 0);
      v.inf  = (e == 8'hFF) && (b[22:0] == 0);
      v.zero = (e == 8'h00) && (b[22:0] == 0);
      v.mant = {(e != 8'h00), b[22:0]};
      v.xp   = ((e == 8'h00) ? 1 : int'(e)) - 150;
      v.raw  = b;
      return v;
    endfunction

    function fp_val_t from_f16(logic [15:0] h);
      fp_val_t v;
      logic [4:0] e;
      e      = h[14:10];
      v.sgn  = h[15];
      v.nan  = (e == 5'h1F) && (h[9:0] != 0);
      v.inf  = (e == 5'h1F) && (h[9:0] == 0);
      v.zero = (e == 5'h00) && (h[9:0] == 0);
      v.mant = {13'b0, (e != 5'h00), h[9:0]};
      v.xp   = ((e == 5'h00) ? 1 : int'(e)) - 25;
      v.raw  = '0;
      return v;
    endfunction

    // m * 2^x to fp32, nearest-even, subnormals kept
    function logic [31:0] round_f32(bit s, logic [127:0] m, int x);
      int           p;
      int           lsbw;
      int           sh;
      int           biased;
      logic [127:0] q;
      bit           half;
      bit           sticky;
      if (m == 0) return {s, 31'b0};
      p = 0;
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      lsbw = (x + p - 23 > -149) ? x + p - 23 : -149;
      sh   = lsbw - x;
      half = 0;
      sticky = 0;
      if (sh <= 0) begin
        q = m << (-sh);
      end else if (sh >= 128) begin
        q = 0;
        sticky = 1;
      end else begin
        q      = m >> sh;
        half   = m[sh-1];
        sticky = |(m & ((128'd1 << (sh - 1)) - 128'd1));
      end
      if (half && (sticky || q[0])) q = q + 1;
      if (q[24]) begin
        q = q >> 1;
        lsbw++;
      end
      if (q < 128'h80_0000) return {s, 8'd0, q[22:0]};
      biased = lsbw + 150;
      if (biased >= 255) return {s, 8'hFF, 23'b0};
      return {s, biased[7:0], q[22:0]};
    endfunction

    function logic [31:0] fmul(fp_val_t a, fp_val_t b);
      bit s;
      s = a.sgn ^ b.sgn;
      if (a.nan || b.nan || (a.inf && b.zero) || (a.zero && b.inf)) return QNAN;
      if (a.inf || b.inf) return {s, PINF[30:0]};
      if (a.zero || b.zero) return {s, 31'b0};
      return round_f32(s, 128'(a.mant) * 128'(b.mant), a.xp + b.xp);
    endfunction

    function logic [31:0] fadd(fp_val_t a, fp_val_t b);
      fp_val_t      t;
      int           d;
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] m;
      bit           s;
      if (a.nan || b.nan) return QNAN;
      if (a.inf && b.inf) return (a.sgn != b.sgn) ? QNAN : a.raw;
      if (a.inf) return a.raw;
      if (b.inf) return b.raw;
      if (a.zero && b.zero) return {a.sgn & b.sgn, 31'b0};
      if (a.zero) return b.raw;
      if (b.zero) return a.raw;
      if (a.xp < b.xp) begin
        t = a;
        a = b;
        b = t;
      end
      d  = a.xp - b.xp;
      ma = 128'(a.mant) << 40;
      if (d <= 40) mb = 128'(b.mant) << (40 - d);
      else if (d - 40 >= 24) mb = 128'd1;   // far below: sticky only
      else mb = (128'(b.mant) >> (d - 40)) |
                128'((b.mant & ((24'd1 << (d - 40)) - 24'd1)) != 0);
      if (a.sgn == b.sgn) begin
        m = ma + mb;
        s = a.sgn;
      end else if (ma >= mb) begin
        m = ma - mb;
        s = a.sgn;
      end else begin
        m = mb - ma;
        s = b.sgn;
      end
      if (m == 0) return 32'h0000_0000;
      return round_f32(s, m, a.xp - 40);
    endfunction

    function void note_item(logic [559:0] d, logic last);
      int          dot;
      fp_val_t     dv;
      logic [31:0] scale;
      logic [31:0] prod;
      for (int i = 0; i < 32; i++)
        dot += int'($signed(d[8*i +: 8])) * int'($signed(d[256 + 8*i +: 8]));
      scale = fmul(from_f16(d[527:512]), from_f32(d[559:528]));
      dv.sgn  = dot < 0;
      dv.nan  = 0;
      dv.inf  = 0;
      dv.zero = dot == 0;
      dv.mant = 24'((dot < 0) ? -dot : dot);
      dv.xp   = 0;
      dv.raw  = '0;
      prod = fmul(from_f32(scale), dv);
      acc  = fadd(from_f32(acc), from_f32(prod));
      if (last) begin
        row_sums_q.push_back(((acc[30:23] == 8'hFF) && (acc[22:0] != 0)) ? QNAN : acc);
        acc = 32'h0000_0000;
      end
    endfunction

    function void check_sum(logic [31:0] got);
      logic [31:0] want;
      if (row_sums_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected row sum %h", got);
        return;
      end
      want = row_sums_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("row sum mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [559:0] in_tdata;    // weights_0..3, acts_0..3, weight_scale, act_scale
  logic         in_tlast;    // last_of_row
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;   // row_sum

  row_sum_board sb;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           cycles;

  q8_block_scaled_dot_accumulate_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Accepted items feed the predictor, accepted sums are checked
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_item(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_sum(out_tdata);
  end

  // Receiver back-pressure, random per cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("q8_block_scaled_dot_accumulate_unit test failed");
      $finish;
    end
  end

  // Hand one sub-block over, with random idle cycles ahead of it
  task automatic send_item(input logic [559:0] d, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [255:0] rand_lanes();
    logic [255:0] r;
    for (int i = 0; i < 8; i++) r[32*i +: 32] = $urandom;
    // sometimes shrink the lanes so small dots are common too
    if ($urandom_range(3) == 0)
      for (int i = 0; i < 32; i++) r[8*i +: 8] = $signed(r[8*i +: 3]);
    return r;
  endfunction

  function automatic logic [15:0] rand_wscale();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(20, 10)), 10'($urandom)};
  endfunction

  function automatic logic [31:0] rand_ascale();
    if ($urandom_range(3) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(140, 110)), 23'($urandom)};
  endfunction

  localparam logic [255:0] ALL_MIN = {32{8'h80}};
  localparam logic [255:0] ALL_MAX = {32{8'h7F}};
  localparam logic [255:0] ALL_ONE = {32{8'h01}};
  localparam logic [15:0]  H_ONE   = 16'h3C00;
  localparam logic [31:0]  F_ONE   = 32'h3F80_0000;

  initial begin
    sb             = new();
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tlast       <= 1'b0;
    out_tready     <= 1'b0;
    cycles         <= 0;
    send_idle_pct  = 7;
    recv_stall_pct = 51;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: largest dots, specials of both scales, overflow, cancel
    send_item({F_ONE, H_ONE, ALL_MIN, ALL_MIN}, 1'b1);
    send_item({F_ONE, H_ONE, ALL_MIN, ALL_MAX}, 1'b1);
    send_item({F_ONE, 16'h7C00, 256'd0, ALL_MAX}, 1'b1);          // inf * 0
    send_item({F_ONE, 16'h7E01, rand_lanes(), rand_lanes()}, 1'b1);
    send_item({32'h0000_0001, 16'h0001, rand_lanes(), rand_lanes()}, 1'b0);
    send_item({F_ONE, 16'h8000, rand_lanes(), rand_lanes()}, 1'b1);
    send_item({32'h7F80_0000, H_ONE, ALL_ONE, ALL_ONE}, 1'b0);
    send_item({32'hFF80_0000, H_ONE, ALL_ONE, ALL_ONE}, 1'b1);    // inf + -inf
    send_item({32'h7F7F_FFFF, 16'h7BFF, ALL_MIN, ALL_MIN}, 1'b1); // overflow
    send_item({32'h7FA0_0001, H_ONE, rand_lanes(), rand_lanes()}, 1'b1);
    send_item({32'h0040_0000, H_ONE, ALL_ONE, ALL_ONE}, 1'b0);    // subnormals
    send_item({32'h8000_0001, H_ONE, ALL_ONE, ALL_MAX}, 1'b1);
    send_item({F_ONE, 16'h03FF, ALL_MAX, ALL_MAX}, 1'b1);
    send_item({F_ONE, H_ONE, ALL_ONE, ALL_ONE}, 1'b0);            // exact cancel
    send_item({32'hBF80_0000, H_ONE, ALL_ONE, ALL_ONE}, 1'b1);
    send_item({32'hFFFF_FFFF, 16'hFFFF, {8{32'hFFFF_FFFF}}, {8{32'hFFFF_FFFF}}}, 1'b1);
    for (int i = 0; i < 4; i++)
      send_item({rand_ascale(), rand_wscale(), rand_lanes(), rand_lanes()}, i == 3);

    // random rows under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 7 : (ph == 1) ? 51 : 0;
      recv_stall_pct = (ph == 0) ? 51 : (ph == 1) ? 7 : 0;
      for (int i = 0; i < 345; i++)
        send_item({rand_ascale(), rand_wscale(), rand_lanes(), rand_lanes()},
                  ($urandom_range(3) == 0) || (i == 344));
    end
    in_tvalid <= 1'b0;

    while (sb.row_sums_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("q8_block_scaled_dot_accumulate_unit test passed");
    end else begin
      $display("q8_block_scaled_dot_accumulate_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
